[rtl/core/csb_pkg.sv]
// Shared constants and types for the clipped sub-rectangle blitter.
package csb_pkg;

    localparam int COLOR_W = 8;
    localparam int SIDE_W  = 13;
    localparam int COORD_W = 16;
    localparam int POS_W   = 12;
    localparam int ADDR_W  = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [COLOR_W-1:0] ALPHA_MIN = 8'd16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LEFT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TOP    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_LEFT     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_TOP      = 4'd7;

    // One drawable pixel: framebuffer column and row plus its color.
    typedef struct packed {
        logic [POS_W-1:0]   dx;
        logic [POS_W-1:0]   dy;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } csb_item_t;

    // Queue status seen by the back end.
    typedef struct packed {
        logic      empty;
        csb_item_t head;
    } csb_queue_stat_t;

endpackage

[rtl/core/csb_ifs.sv]
// Channel interfaces: source pixels, framebuffer writes, register writes.
interface pixel_if;
    logic                          valid;
    logic                          ready;
    logic [csb_pkg::COLOR_W-1:0]   pixel_alpha;
    logic [csb_pkg::COLOR_W-1:0]   pixel_red;
    logic [csb_pkg::COLOR_W-1:0]   pixel_green;
    logic [csb_pkg::COLOR_W-1:0]   pixel_blue;

    modport source (output valid, pixel_alpha, pixel_red, pixel_green, pixel_blue,
                    input ready);
    modport sink (input valid, pixel_alpha, pixel_red, pixel_green, pixel_blue,
                  output ready);
endinterface

interface fb_if;
    logic                          valid;
    logic                          ready;
    logic [csb_pkg::ADDR_W-1:0]    fb_address;
    logic [csb_pkg::COLOR_W-1:0]   out_red;
    logic [csb_pkg::COLOR_W-1:0]   out_green;
    logic [csb_pkg::COLOR_W-1:0]   out_blue;

    modport source (output valid, fb_address, out_red, out_green, out_blue,
                    input ready);
    modport sink (input valid, fb_address, out_red, out_green, out_blue,
                  output ready);
endinterface

interface cfg_if;
    logic                            valid;
    logic                            ready;
    logic [csb_pkg::CFG_IDX_W-1:0]   index;
    logic [csb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/clipped_subrect_blitter.sv]
// Clipped sub-rectangle sprite blitter: top level joining front end, queue and back end.
// Source pixels stream in raster order on the pixel channel, one per clock at full
// rate while the queue is not full; register writes on the cfg channel are always
// accepted and take effect on the next pixel. Each pixel that lies in the source
// sub-rectangle clipped to the image, lands inside the framebuffer and has alpha of
// at least 16 produces one framebuffer write request; others only advance the raster
// counters. An accepted request is written into the four-entry queue, and the back end
// pops it into the output register, loading the address multiply. The front end
// keeps taking pixels while fb stalls until the queue and output register hold five
// pending requests.
module clipped_subrect_blitter #(
    parameter int FB_WIDTH       = 1024,
    parameter int FB_HEIGHT      = 768,
    parameter int IMAGE_MAX_SIDE = 4096
) (
    input  logic  clk,
    input  logic  rst_n,
    pixel_if.sink pixel,
    cfg_if.sink   cfg,
    fb_if.source  fb
);
    import csb_pkg::*;

    logic            push;
    logic            pop;
    logic            queue_full;
    csb_item_t       push_item;
    csb_queue_stat_t queue_stat;

    csb_front #(
        .FB_WIDTH       (FB_WIDTH),
        .FB_HEIGHT      (FB_HEIGHT),
        .IMAGE_MAX_SIDE (IMAGE_MAX_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    csb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .stat      (queue_stat)
    );

    csb_back #(
        .FB_WIDTH (FB_WIDTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (queue_stat),
        .pop   (pop),
        .fb    (fb)
    );

endmodule

[rtl/core/csb_front.sv]
// Front end: register file, raster counters and per-pixel clip and alpha test.
module csb_front #(
    parameter int FB_WIDTH       = 1024,
    parameter int FB_HEIGHT      = 768,
    parameter int IMAGE_MAX_SIDE = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    pixel_if.sink               pixel,
    cfg_if.sink                 cfg,
    input  logic                queue_full,
    output logic                push,
    output csb_pkg::csb_item_t  push_item
);
    import csb_pkg::*;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] pos;
    } axis_t;

    localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(IMAGE_MAX_SIDE);
    localparam logic [SIDE_W-1:0] FB_W_LIM = SIDE_W'(FB_WIDTH);
    localparam logic [SIDE_W-1:0] FB_H_LIM = SIDE_W'(FB_HEIGHT);

    logic [SIDE_W-1:0]  image_width_reg;
    logic [SIDE_W-1:0]  image_height_reg;
    logic [COORD_W-1:0] source_left_reg;
    logic [COORD_W-1:0] source_top_reg;
    logic [SIDE_W-1:0]  region_width_reg;
    logic [SIDE_W-1:0]  region_height_reg;
    logic [COORD_W-1:0] dest_left_reg;
    logic [COORD_W-1:0] dest_top_reg;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;

    logic [SIDE_W-1:0] side_w;
    logic [SIDE_W-1:0] side_h;
    logic              accept;
    logic              col_wrap;
    logic              row_wrap;
    axis_t             x_axis;
    axis_t             y_axis;

    // Position p inside [origin, origin+len), inside the image side, and
    // landing inside [0, limit) on the framebuffer.
    function automatic axis_t axis_check(
        input logic [POS_W-1:0]   p,
        input logic [SIDE_W-1:0]  side,
        input logic [COORD_W-1:0] origin,
        input logic [SIDE_W-1:0]  len,
        input logic [COORD_W-1:0] dest,
        input logic [SIDE_W-1:0]  limit
    );
        logic signed [17:0] off;
        logic signed [17:0] dst;
        axis_t              res;
        off = $signed({6'b0, p}) - $signed({{2{origin[COORD_W-1]}}, origin});
        dst = $signed({{2{dest[COORD_W-1]}}, dest}) + off;
        res.ok = ({1'b0, p} < side) && (off >= 18'sd0)
                 && (off < $signed({5'b0, len}))
                 && (dst >= 18'sd0) && (dst < $signed({5'b0, limit}));
        res.pos = dst[POS_W-1:0];
        return res;
    endfunction

    assign side_w = (image_width_reg > MAX_SIDE) ? MAX_SIDE : image_width_reg;
    assign side_h = (image_height_reg > MAX_SIDE) ? MAX_SIDE : image_height_reg;

    assign x_axis = axis_check(col_reg, side_w, source_left_reg, region_width_reg,
                               dest_left_reg, FB_W_LIM);
    assign y_axis = axis_check(row_reg, side_h, source_top_reg, region_height_reg,
                               dest_top_reg, FB_H_LIM);

    assign pixel.ready = !queue_full;
    assign accept      = pixel.valid && pixel.ready;
    assign cfg.ready   = 1'b1;

    assign push = accept && x_axis.ok && y_axis.ok && (pixel.pixel_alpha >= ALPHA_MIN);
    assign push_item.dx    = x_axis.pos;
    assign push_item.dy    = y_axis.pos;
    assign push_item.red   = pixel.pixel_red;
    assign push_item.green = pixel.pixel_green;
    assign push_item.blue  = pixel.pixel_blue;

    assign col_wrap = ({1'b0, col_reg} + 13'd1) >= side_w;
    assign row_wrap = ({1'b0, row_reg} + 13'd1) >= side_h;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + 12'd1;
            end
            else
            begin
                col_next = col_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 13'd32;
            image_height_reg  <= 13'd32;
            source_left_reg   <= '0;
            source_top_reg    <= '0;
            region_width_reg  <= 13'd32;
            region_height_reg <= 13'd32;
            dest_left_reg     <= '0;
            dest_top_reg      <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg.data[SIDE_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg.data[SIDE_W-1:0];
                REG_SOURCE_LEFT:   source_left_reg   <= cfg.data;
                REG_SOURCE_TOP:    source_top_reg    <= cfg.data;
                REG_REGION_WIDTH:  region_width_reg  <= cfg.data[SIDE_W-1:0];
                REG_REGION_HEIGHT: region_height_reg <= cfg.data[SIDE_W-1:0];
                REG_DEST_LEFT:     dest_left_reg     <= cfg.data;
                REG_DEST_TOP:      dest_top_reg      <= cfg.data;
                default:           ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_col_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && col_wrap |=> col_reg == '0)
        else $error("column counter did not wrap at the image edge");
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !push)
        else $error("pixel request pushed into a full queue");
`endif

endmodule

[rtl/core/csb_queue.sv]
// Short queue between the classifying front end and the address back end.
module csb_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  csb_pkg::csb_item_t       push_item,
    output logic                     full,
    input  logic                     pop,
    output csb_pkg::csb_queue_stat_t stat
);
    import csb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    csb_item_t         slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;

    assign full       = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign stat.head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue popped while empty");
    a_count_tracks_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> wr_ptr_reg == rd_ptr_reg + count_reg[PTR_W-1:0])
        else $error("queue count disagrees with pointers");
`endif

endmodule

[rtl/core/csb_back.sv]
// Back end: turn column and row into a framebuffer word address and hold the write.
module csb_back #(
    parameter int FB_WIDTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  csb_pkg::csb_queue_stat_t stat,
    output logic                     pop,
    fb_if.source                     fb
);
    import csb_pkg::*;

    localparam logic [SIDE_W-1:0] FB_W_MUL = SIDE_W'(FB_WIDTH);
    localparam int PROD_W = POS_W + SIDE_W;

    logic                 valid_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [COLOR_W-1:0]   red_reg;
    logic [COLOR_W-1:0]   green_reg;
    logic [COLOR_W-1:0]   blue_reg;
    logic [PROD_W-1:0]    addr_full;
    logic                 can_load;

    assign can_load  = !valid_reg || fb.ready;
    assign pop       = !stat.empty && can_load;
    assign addr_full = stat.head.dy * FB_W_MUL + {{SIDE_W{1'b0}}, stat.head.dx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= !stat.empty;
        end
    end

    // Payload loads on every pop and holds while the write request stalls.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg  <= addr_full[ADDR_W-1:0];
            red_reg   <= stat.head.red;
            green_reg <= stat.head.green;
            blue_reg  <= stat.head.blue;
        end
    end

    assign fb.valid      = valid_reg;
    assign fb.fb_address = addr_reg;
    assign fb.out_red    = red_reg;
    assign fb.out_green  = green_reg;
    assign fb.out_blue   = blue_reg;

`ifndef NO_ASSERTIONS
    a_pop_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> fb.valid)
        else $error("popped pixel did not reach the output register");
`endif

endmodule
